FILE: rtl/core/msd_pkg.sv
// Shared types, codes and tag decode for the MessagePack stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package msd_pkg;

    localparam logic [3:0] KIND_NONE   = 4'd0;
    localparam logic [3:0] KIND_NIL    = 4'd1;
    localparam logic [3:0] KIND_BOOL   = 4'd2;
    localparam logic [3:0] KIND_INT    = 4'd3;
    localparam logic [3:0] KIND_F32    = 4'd4;
    localparam logic [3:0] KIND_F64    = 4'd5;
    localparam logic [3:0] KIND_STR    = 4'd6;
    localparam logic [3:0] KIND_STRB   = 4'd7;
    localparam logic [3:0] KIND_ARRAY  = 4'd8;
    localparam logic [3:0] KIND_MAP    = 4'd9;

    localparam logic [2:0] STAT_RUNNING   = 3'd0;
    localparam logic [2:0] STAT_COMPLETE  = 3'd1;
    localparam logic [2:0] STAT_TRUNCATED = 3'd2;
    localparam logic [2:0] STAT_BAD_TAG   = 3'd3;
    localparam logic [2:0] STAT_TRAILING  = 3'd4;
    localparam logic [2:0] STAT_EMPTY     = 3'd5;
    localparam logic [2:0] STAT_TOO_DEEP  = 3'd6;

    localparam logic [7:0] TAG_POSFIX_MAX = 8'h7f;
    localparam logic [7:0] TAG_NEGFIX_MIN = 8'he0;
    localparam logic [7:0] TAG_FIXSTR_MIN = 8'ha0;
    localparam logic [7:0] TAG_FIXSTR_MAX = 8'hbf;
    localparam logic [7:0] TAG_FIXARR_MIN = 8'h90;
    localparam logic [7:0] TAG_FIXARR_MAX = 8'h9f;
    localparam logic [7:0] TAG_FIXMAP_MIN = 8'h80;
    localparam logic [7:0] TAG_FIXMAP_MAX = 8'h8f;
    localparam logic [7:0] TAG_NIL        = 8'hc0;
    localparam logic [7:0] TAG_FALSE      = 8'hc2;
    localparam logic [7:0] TAG_TRUE       = 8'hc3;
    localparam logic [7:0] TAG_F32        = 8'hca;
    localparam logic [7:0] TAG_F64        = 8'hcb;
    localparam logic [7:0] TAG_U8         = 8'hcc;
    localparam logic [7:0] TAG_U16        = 8'hcd;
    localparam logic [7:0] TAG_U32        = 8'hce;
    localparam logic [7:0] TAG_U64        = 8'hcf;
    localparam logic [7:0] TAG_I8         = 8'hd0;
    localparam logic [7:0] TAG_I16        = 8'hd1;
    localparam logic [7:0] TAG_I32        = 8'hd2;
    localparam logic [7:0] TAG_I64        = 8'hd3;
    localparam logic [7:0] TAG_STR8       = 8'hd9;
    localparam logic [7:0] TAG_STR16      = 8'hda;
    localparam logic [7:0] TAG_STR32      = 8'hdb;
    localparam logic [7:0] TAG_ARR16      = 8'hdc;
    localparam logic [7:0] TAG_ARR32      = 8'hdd;
    localparam logic [7:0] TAG_MAP16      = 8'hde;
    localparam logic [7:0] TAG_MAP32      = 8'hdf;

    localparam logic [4:0] DEPTH_LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] token_value;
        logic        is_map_key;
        logic [4:0]  nesting_depth;
        logic [2:0]  status;
    } token_t;

    // One open container: map flag and items still due (a map counts keys and values).
    typedef struct packed {
        logic        is_map;
        logic [32:0] count;
    } stack_entry_t;

    function automatic logic [3:0] header_len(input logic [7:0] tag);
        logic [3:0] len;
        begin
            case (tag)
                TAG_U8, TAG_I8, TAG_STR8:                           len = 4'd1;
                TAG_U16, TAG_I16, TAG_STR16, TAG_ARR16, TAG_MAP16:  len = 4'd2;
                TAG_F32, TAG_U32, TAG_I32, TAG_STR32, TAG_ARR32,
                TAG_MAP32:                                          len = 4'd4;
                TAG_F64, TAG_U64, TAG_I64:                          len = 4'd8;
                default:                                            len = 4'd0;
            endcase
            return len;
        end
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/msd_if.sv
// Valid/ready stream interfaces for input bytes and output tokens.
`timescale 1ns / 1ps
`default_nettype none
interface msd_in_if;
    import msd_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface msd_out_if;
    import msd_pkg::*;
    logic   valid;
    logic   ready;
    token_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/msgpack_stream_decoder.sv
// Top level: MessagePack byte stream to token stream decoder.
// Takes one byte (or the end marker) per beat and returns exactly one token beat for it.
// When a value closes containers, the decoder refills the top register with one
// memory read of the container stack for each level that it closes while another
// container still encloses it; no input is taken meanwhile. The top open container
// is held in a register and the ones below it in the stack memory.
// The input stays stalled while a token waits in the output register and is not taken.
// The user must write depth_limit through cfg_wr_en/cfg_wr_data only while idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module msgpack_stream_decoder #(
    parameter int MAX_DEPTH = 16
) (
    input  wire        clk,
    input  wire        rst_n,
    msd_in_if.sink     item,
    msd_out_if.source  token,
    input  wire        cfg_wr_en,
    input  wire  [4:0] cfg_wr_data
);
    import msd_pkg::*;

    localparam int SPW = $clog2(MAX_DEPTH + 1);
    localparam int AW  = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LW  = (SPW > 5) ? SPW : 5;

    localparam logic [1:0] PH_TAG    = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_STRING = 2'd2;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOAD = 1'b1;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_SCALAR = 2'd1;
    localparam logic [1:0] ACT_STR    = 2'd2;
    localparam logic [1:0] ACT_CONT   = 2'd3;

    logic            st_reg, st_next;
    logic [1:0]      phase_reg, phase_next;
    logic [3:0]      hdr_left_reg, hdr_left_next;
    logic [63:0]     acc_reg, acc_next;
    logic [7:0]      ptag_reg, ptag_next;
    logic [31:0]     str_left_reg, str_left_next;
    stack_entry_t    top_reg, top_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic            top_done_reg, top_done_next;
    logic [2:0]      err_reg, err_next;
    logic            seen_reg, seen_next;
    logic [4:0]      lim_reg;
    token_t          out_reg, out_next;
    logic            out_valid_reg, out_valid_next;

    logic            accept;
    logic            key_due;
    logic [LW-1:0]   sp_w;
    logic [LW-1:0]   lim_eff;
    logic [7:0]      b;
    logic            is_str;
    logic [3:0]      hlen;
    logic [1:0]      act;
    logic [3:0]      act_kind;
    logic [63:0]     act_val;
    logic            act_map;
    logic [31:0]     act_len;
    logic            done_req;
    logic [32:0]     left;
    logic [SPW-1:0]  sp_dec;
    logic [SPW-1:0]  sp_dec2;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    stack_entry_t    mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    stack_entry_t    mem_rdata;

    msd_stack_mem #(
        .DEPTH (MAX_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign item.ready    = (st_reg == ST_IDLE) && (!out_valid_reg || token.ready);
    assign accept        = item.valid && item.ready;
    assign token.valid   = out_valid_reg;
    assign token.payload = out_reg;

    assign b       = item.payload.data_byte;
    assign sp_w    = LW'(sp_reg);
    assign lim_eff = (LW'(lim_reg) > LW'(MAX_DEPTH)) ? LW'(MAX_DEPTH) : LW'(lim_reg);
    assign key_due = (sp_reg != '0) && top_reg.is_map && !top_reg.count[0];
    assign is_str  = ((b >= TAG_FIXSTR_MIN) && (b <= TAG_FIXSTR_MAX)) ||
                     (b == TAG_STR8) || (b == TAG_STR16) || (b == TAG_STR32);
    assign hlen    = header_len(b);
    assign sp_dec  = sp_reg - 1'b1;
    assign sp_dec2 = sp_reg - 2'd2;

    always_comb
    begin
        st_next        = st_reg;
        phase_next     = phase_reg;
        hdr_left_next  = hdr_left_reg;
        acc_next       = acc_reg;
        ptag_next      = ptag_reg;
        str_left_next  = str_left_reg;
        top_next       = top_reg;
        sp_next        = sp_reg;
        top_done_next  = top_done_reg;
        err_next       = err_reg;
        seen_next      = seen_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !token.ready;
        act            = ACT_NONE;
        act_kind       = KIND_NONE;
        act_val        = '0;
        act_map        = 1'b0;
        act_len        = '0;
        done_req       = 1'b0;
        left           = '0;
        mem_we         = 1'b0;
        mem_waddr      = sp_dec[AW-1:0];
        mem_wdata      = top_reg;
        mem_re         = 1'b0;
        mem_raddr      = sp_dec2[AW-1:0];

        if (st_reg == ST_IDLE)
        begin
            if (accept)
            begin
                out_valid_next         = 1'b1;
                out_next.token_kind    = KIND_NONE;
                out_next.token_value   = '0;
                out_next.is_map_key    = 1'b0;
                out_next.nesting_depth = sp_w[4:0];
                out_next.status        = STAT_RUNNING;

                if (item.payload.end_marker)
                begin
                    out_next.nesting_depth = '0;
                    if (err_reg != STAT_RUNNING)
                        out_next.status = err_reg;
                    else if (!seen_reg)
                        out_next.status = STAT_EMPTY;
                    else if (top_done_reg)
                        out_next.status = STAT_COMPLETE;
                    else
                        out_next.status = STAT_TRUNCATED;
                    phase_next    = PH_TAG;
                    hdr_left_next = '0;
                    acc_next      = '0;
                    ptag_next     = '0;
                    str_left_next = '0;
                    sp_next       = '0;
                    top_done_next = 1'b0;
                    err_next      = STAT_RUNNING;
                    seen_next     = 1'b0;
                end
                else if (err_reg != STAT_RUNNING)
                begin
                    out_next.status = err_reg;
                end
                else
                begin
                    seen_next = 1'b1;
                    if (top_done_reg)
                    begin
                        err_next        = STAT_TRAILING;
                        out_next.status = STAT_TRAILING;
                    end
                    else if (phase_reg == PH_STRING)
                    begin
                        out_next.token_kind  = KIND_STRB;
                        out_next.token_value = 64'(b);
                        out_next.is_map_key  = key_due;
                        str_left_next        = str_left_reg - 1'b1;
                        if (str_left_reg == 32'd1)
                        begin
                            phase_next = PH_TAG;
                            done_req   = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_HEADER)
                    begin
                        acc_next      = {acc_reg[55:0], b};
                        hdr_left_next = hdr_left_reg - 1'b1;
                        if (hdr_left_reg == 4'd1)
                        begin
                            phase_next = PH_TAG;
                            case (ptag_reg)
                                TAG_F32:
                                begin
                                    act = ACT_SCALAR; act_kind = KIND_F32;
                                    act_val = 64'(acc_next[31:0]);
                                end
                                TAG_F64:
                                begin
                                    act = ACT_SCALAR; act_kind = KIND_F64; act_val = acc_next;
                                end
                                TAG_I8:
                                begin
                                    act = ACT_SCALAR; act_kind = KIND_INT;
                                    act_val = {{56{acc_next[7]}}, acc_next[7:0]};
                                end
                                TAG_I16:
                                begin
                                    act = ACT_SCALAR; act_kind = KIND_INT;
                                    act_val = {{48{acc_next[15]}}, acc_next[15:0]};
                                end
                                TAG_I32:
                                begin
                                    act = ACT_SCALAR; act_kind = KIND_INT;
                                    act_val = {{32{acc_next[31]}}, acc_next[31:0]};
                                end
                                TAG_STR8, TAG_STR16, TAG_STR32:
                                begin
                                    act = ACT_STR; act_len = acc_next[31:0];
                                end
                                TAG_ARR16, TAG_ARR32:
                                begin
                                    act = ACT_CONT; act_map = 1'b0; act_len = acc_next[31:0];
                                end
                                TAG_MAP16, TAG_MAP32:
                                begin
                                    act = ACT_CONT; act_map = 1'b1; act_len = acc_next[31:0];
                                end
                                default:
                                begin
                                    act = ACT_SCALAR; act_kind = KIND_INT; act_val = acc_next;
                                end
                            endcase
                        end
                    end
                    else
                    begin
                        if (key_due && !is_str)
                        begin
                            err_next        = STAT_BAD_TAG;
                            out_next.status = STAT_BAD_TAG;
                        end
                        else if (b <= TAG_POSFIX_MAX)
                        begin
                            act = ACT_SCALAR; act_kind = KIND_INT; act_val = 64'(b);
                        end
                        else if (b >= TAG_NEGFIX_MIN)
                        begin
                            act = ACT_SCALAR; act_kind = KIND_INT; act_val = {{56{1'b1}}, b};
                        end
                        else if ((b >= TAG_FIXSTR_MIN) && (b <= TAG_FIXSTR_MAX))
                        begin
                            act = ACT_STR; act_len = 32'(b[4:0]);
                        end
                        else if ((b >= TAG_FIXARR_MIN) && (b <= TAG_FIXARR_MAX))
                        begin
                            act = ACT_CONT; act_map = 1'b0; act_len = 32'(b[3:0]);
                        end
                        else if ((b >= TAG_FIXMAP_MIN) && (b <= TAG_FIXMAP_MAX))
                        begin
                            act = ACT_CONT; act_map = 1'b1; act_len = 32'(b[3:0]);
                        end
                        else if (b == TAG_NIL)
                        begin
                            act = ACT_SCALAR; act_kind = KIND_NIL;
                        end
                        else if ((b == TAG_FALSE) || (b == TAG_TRUE))
                        begin
                            act = ACT_SCALAR; act_kind = KIND_BOOL; act_val = 64'(b[0]);
                        end
                        else if (hlen == 4'd0)
                        begin
                            err_next        = STAT_BAD_TAG;
                            out_next.status = STAT_BAD_TAG;
                        end
                        else
                        begin
                            ptag_next     = b;
                            hdr_left_next = hlen;
                            acc_next      = '0;
                            phase_next    = PH_HEADER;
                        end
                    end
                end

                case (act)
                    ACT_SCALAR:
                    begin
                        out_next.token_kind  = act_kind;
                        out_next.token_value = act_val;
                        done_req             = 1'b1;
                    end
                    ACT_STR:
                    begin
                        out_next.token_kind  = KIND_STR;
                        out_next.token_value = 64'(act_len);
                        out_next.is_map_key  = key_due;
                        if (act_len == '0)
                            done_req = 1'b1;
                        else
                        begin
                            phase_next    = PH_STRING;
                            str_left_next = act_len;
                        end
                    end
                    ACT_CONT:
                    begin
                        if (sp_w >= lim_eff)
                        begin
                            err_next        = STAT_TOO_DEEP;
                            out_next.status = STAT_TOO_DEEP;
                        end
                        else
                        begin
                            out_next.token_kind  = act_map ? KIND_MAP : KIND_ARRAY;
                            out_next.token_value = 64'(act_len);
                            if (act_len == '0)
                                done_req = 1'b1;
                            else
                            begin
                                // spill the current top below the new entry
                                mem_we         = (sp_reg != '0);
                                top_next.is_map = act_map;
                                top_next.count  = act_map ? {act_len, 1'b0} : {1'b0, act_len};
                                sp_next        = sp_reg + 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase

                if (done_req)
                begin
                    if (sp_reg == '0)
                        top_done_next = 1'b1;
                    else
                    begin
                        left = top_reg.count - 33'd1;
                        if (left != '0)
                            top_next.count = left;
                        else
                        begin
                            sp_next = sp_dec;
                            if (sp_dec == '0)
                                top_done_next = 1'b1;
                            else
                            begin
                                mem_re  = 1'b1;
                                st_next = ST_LOAD;
                            end
                        end
                    end
                end
            end
        end
        else
        begin
            // refill top from memory and retire one item of it
            left     = mem_rdata.count - 33'd1;
            top_next = mem_rdata;
            st_next  = ST_IDLE;
            if (left != '0)
                top_next.count = left;
            else
            begin
                sp_next = sp_dec;
                if (sp_dec == '0)
                    top_done_next = 1'b1;
                else
                begin
                    mem_re  = 1'b1;
                    st_next = ST_LOAD;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            phase_reg     <= PH_TAG;
            hdr_left_reg  <= '0;
            acc_reg       <= '0;
            ptag_reg      <= '0;
            str_left_reg  <= '0;
            sp_reg        <= '0;
            top_done_reg  <= 1'b0;
            err_reg       <= STAT_RUNNING;
            seen_reg      <= 1'b0;
            lim_reg       <= DEPTH_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            phase_reg     <= phase_next;
            hdr_left_reg  <= hdr_left_next;
            acc_reg       <= acc_next;
            ptag_reg      <= ptag_next;
            str_left_reg  <= str_left_next;
            sp_reg        <= sp_next;
            top_done_reg  <= top_done_next;
            err_reg       <= err_next;
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                lim_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        out_reg <= out_next;
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(sp_reg) <= LW'(MAX_DEPTH))
        else $error("stack pointer beyond depth");

    a_load_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_LOAD) |-> (sp_reg != '0))
        else $error("stack refill with empty stack");

    a_accept_token: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted beat produced no token");

    a_no_push_in_load: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_LOAD) |-> !mem_we)
        else $error("stack write during refill");
endmodule
`default_nettype wire

FILE: rtl/core/msd_stack_mem.sv
// Container stack memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module msd_stack_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire                          clk,
    input  wire                          wr_en,
    input  wire  [AW-1:0]                wr_addr,
    input  wire  msd_pkg::stack_entry_t  wr_data,
    input  wire                          rd_en,
    input  wire  [AW-1:0]                rd_addr,
    output msd_pkg::stack_entry_t        rd_data
);
    import msd_pkg::*;

    stack_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

FILE: test/msd_token_checker.sv
// Token checker: mirrors the decoder state, predicts each token and compares it.
`timescale 1ns / 1ps
`default_nettype none
module msd_token_checker (
    input  wire         clk,
    input  wire         rst_n,
    msd_in_if           in_ch,
    msd_out_if          out_ch,
    input  wire         cfg_wr_en,
    input  wire  [4:0]  cfg_wr_data,
    output int          mismatches,
    output int          tokens_due
);
    import msd_pkg::*;

    typedef enum logic [1:0] { PH_TAG, PH_HEADER, PH_STRING } parse_phase_e;

    parse_phase_e  ph;
    logic [3:0]    hdr_left;
    logic [63:0]   hdr_acc;
    logic [7:0]    hdr_tag;
    logic [31:0]   str_left;
    stack_entry_t  open_stack [16];
    logic [4:0]    open_cnt;
    logic          top_done;
    logic [2:0]    held_err;
    logic          saw_byte;
    logic [4:0]    depth_lim;

    token_t        token_q [$];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("[%0t] token mismatch: %s got %0h want %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic token_t mk(input logic [3:0] kind, input logic [63:0] val,
                                  input logic key, input logic [4:0] dep,
                                  input logic [2:0] st);
        token_t t;
        t.token_kind = kind;
        t.token_value = val;
        t.is_map_key = key;
        t.nesting_depth = dep;
        t.status = st;
        return t;
    endfunction

    function automatic void clear_parser();
        ph = PH_TAG;
        hdr_left = '0;
        hdr_acc = '0;
        hdr_tag = '0;
        str_left = '0;
        open_cnt = '0;
        top_done = 1'b0;
        held_err = STAT_RUNNING;
        saw_byte = 1'b0;
    endfunction

    function automatic logic key_due();
        if (open_cnt == 0)
            return 1'b0;
        return open_stack[open_cnt-1].is_map && !open_stack[open_cnt-1].count[0];
    endfunction

    // Retire one item from the enclosing containers, closing any that run out.
    function automatic void value_done();
        logic [32:0] left;
        while (open_cnt > 0) begin
            left = open_stack[open_cnt-1].count - 33'd1;
            if (left != 0) begin
                open_stack[open_cnt-1].count = left;
                return;
            end
            open_cnt--;
        end
        top_done = 1'b1;
    endfunction

    function automatic token_t scalar(input logic [3:0] kind, input logic [63:0] val);
        logic [4:0] d;
        d = open_cnt;
        value_done();
        return mk(kind, val, 1'b0, d, STAT_RUNNING);
    endfunction

    function automatic token_t start_string(input logic [31:0] len);
        logic       key;
        logic [4:0] d;
        key = key_due();
        d = open_cnt;
        if (len == 0)
            value_done();
        else
        begin
            ph = PH_STRING;
            str_left = len;
        end
        return mk(KIND_STR, {32'd0, len}, key, d, STAT_RUNNING);
    endfunction

    function automatic token_t open_container(input logic is_map, input logic [31:0] n);
        logic [4:0] d;
        logic [4:0] lim;
        d = open_cnt;
        lim = (depth_lim > 5'd16) ? 5'd16 : depth_lim;
        if (open_cnt >= lim)
        begin
            held_err = STAT_TOO_DEEP;
            return mk(KIND_NONE, '0, 1'b0, d, STAT_TOO_DEEP);
        end
        if (n == 0)
            value_done();
        else
        begin
            open_stack[open_cnt].is_map = is_map;
            open_stack[open_cnt].count = is_map ? {n, 1'b0} : {1'b0, n};
            open_cnt++;
        end
        return mk(is_map ? KIND_MAP : KIND_ARRAY, {32'd0, n}, 1'b0, d, STAT_RUNNING);
    endfunction

    function automatic token_t finish_header();
        logic [63:0] a;
        a = hdr_acc;
        ph = PH_TAG;
        case (hdr_tag)
            TAG_F32:   return scalar(KIND_F32, {32'd0, a[31:0]});
            TAG_F64:   return scalar(KIND_F64, a);
            TAG_I8:    return scalar(KIND_INT, {{56{a[7]}}, a[7:0]});
            TAG_I16:   return scalar(KIND_INT, {{48{a[15]}}, a[15:0]});
            TAG_I32:   return scalar(KIND_INT, {{32{a[31]}}, a[31:0]});
            TAG_STR8, TAG_STR16, TAG_STR32: return start_string(a[31:0]);
            TAG_ARR16, TAG_ARR32: return open_container(1'b0, a[31:0]);
            TAG_MAP16, TAG_MAP32: return open_container(1'b1, a[31:0]);
            default:   return scalar(KIND_INT, a);
        endcase
    endfunction

    function automatic logic [3:0] hdr_bytes(input logic [7:0] t);
        case (t)
            TAG_U8, TAG_I8, TAG_STR8: return 4'd1;
            TAG_U16, TAG_I16, TAG_STR16, TAG_ARR16, TAG_MAP16: return 4'd2;
            TAG_F32, TAG_U32, TAG_I32, TAG_STR32, TAG_ARR32, TAG_MAP32: return 4'd4;
            TAG_F64, TAG_U64, TAG_I64: return 4'd8;
            default: return 4'd0;
        endcase
    endfunction

    function automatic token_t take_tag(input logic [7:0] t);
        logic is_str;
        is_str = (t >= TAG_FIXSTR_MIN && t <= TAG_FIXSTR_MAX) || t == TAG_STR8 ||
                 t == TAG_STR16 || t == TAG_STR32;
        if (key_due() && !is_str)
        begin
            held_err = STAT_BAD_TAG;
            return mk(KIND_NONE, '0, 1'b0, open_cnt, STAT_BAD_TAG);
        end
        if (t <= TAG_POSFIX_MAX)
            return scalar(KIND_INT, {56'd0, t});
        if (t >= TAG_NEGFIX_MIN)
            return scalar(KIND_INT, {{56{1'b1}}, t});
        if (is_str && t <= TAG_FIXSTR_MAX)
            return start_string({27'd0, t[4:0]});
        if (t >= TAG_FIXARR_MIN && t <= TAG_FIXARR_MAX)
            return open_container(1'b0, {28'd0, t[3:0]});
        if (t >= TAG_FIXMAP_MIN && t <= TAG_FIXMAP_MAX)
            return open_container(1'b1, {28'd0, t[3:0]});
        if (t == TAG_NIL)
            return scalar(KIND_NIL, '0);
        if (t == TAG_FALSE || t == TAG_TRUE)
            return scalar(KIND_BOOL, {63'd0, t[0]});
        if (hdr_bytes(t) == 0)
        begin
            held_err = STAT_BAD_TAG;
            return mk(KIND_NONE, '0, 1'b0, open_cnt, STAT_BAD_TAG);
        end
        hdr_tag = t;
        hdr_left = hdr_bytes(t);
        hdr_acc = '0;
        ph = PH_HEADER;
        return mk(KIND_NONE, '0, 1'b0, open_cnt, STAT_RUNNING);
    endfunction

    function automatic token_t decode_beat(input in_item_t it);
        logic [2:0] st;
        logic       key;
        logic [4:0] d;
        if (it.end_marker)
        begin
            if (held_err != STAT_RUNNING)
                st = held_err;
            else if (!saw_byte)
                st = STAT_EMPTY;
            else if (top_done)
                st = STAT_COMPLETE;
            else
                st = STAT_TRUNCATED;
            clear_parser();
            return mk(KIND_NONE, '0, 1'b0, 5'd0, st);
        end
        if (held_err != STAT_RUNNING)
            return mk(KIND_NONE, '0, 1'b0, open_cnt, held_err);
        saw_byte = 1'b1;
        if (top_done)
        begin
            held_err = STAT_TRAILING;
            return mk(KIND_NONE, '0, 1'b0, open_cnt, STAT_TRAILING);
        end
        if (ph == PH_STRING)
        begin
            key = key_due();
            d = open_cnt;
            str_left--;
            if (str_left == 0)
            begin
                ph = PH_TAG;
                value_done();
            end
            return mk(KIND_STRB, {56'd0, it.data_byte}, key, d, STAT_RUNNING);
        end
        if (ph == PH_HEADER)
        begin
            hdr_acc = {hdr_acc[55:0], it.data_byte};
            if (hdr_left > 0)
                hdr_left--;
            if (hdr_left == 0)
                return finish_header();
            return mk(KIND_NONE, '0, 1'b0, open_cnt, STAT_RUNNING);
        end
        return take_tag(it.data_byte);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_t got;
        token_t want;
        if (!rst_n)
        begin
            clear_parser();
            depth_lim = DEPTH_LIMIT_RESET;
            token_q.delete();
            tokens_due = 0;
            mismatches = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.payload;
                if (token_q.size() == 0)
                    report("unexpected token kind", 64'(got.token_kind), '0);
                else
                begin
                    want = token_q.pop_front();
                    if (got.token_kind !== want.token_kind)
                        report("token_kind", 64'(got.token_kind), 64'(want.token_kind));
                    if (got.token_value !== want.token_value)
                        report("token_value", got.token_value, want.token_value);
                    if (got.is_map_key !== want.is_map_key)
                        report("is_map_key", 64'(got.is_map_key), 64'(want.is_map_key));
                    if (got.nesting_depth !== want.nesting_depth)
                        report("nesting_depth", 64'(got.nesting_depth),
                               64'(want.nesting_depth));
                    if (got.status !== want.status)
                        report("status", 64'(got.status), 64'(want.status));
                end
            end
            if (in_ch.valid && in_ch.ready)
                token_q.insert(token_q.size(), decode_beat(in_ch.payload));
            if (cfg_wr_en)
                depth_lim = cfg_wr_data;
            tokens_due = token_q.size();
        end
    end

endmodule
`default_nettype wire

FILE: test/tb.sv
// Testbench top: clock, reset, byte stream stimulus and the final verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import msd_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [4:0] cfg_wr_data;
    int         mismatches;
    int         tokens_due;
    int         beats_sent;
    int         burst_left;
    logic [8:0] byte_q [$];

    msd_in_if  in_ch ();
    msd_out_if out_ch ();

    msgpack_stream_decoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (in_ch),
        .token       (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    msd_token_checker u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .tokens_due  (tokens_due)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #5ms;
        $display("msgpack_stream_decoder regression: fail");
        $finish;
    end

    // Receiver stall pattern: takes turns between free-running, random and one-in-four ready.
    int stall_cyc = 0;
    always @(posedge clk)
    begin
        stall_cyc <= stall_cyc + 1;
        case ((stall_cyc / 200) % 3)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 99) < 55);
            default: out_ch.ready <= (stall_cyc % 4 == 0);
        endcase
    end

    function automatic void put_byte(input logic [7:0] b);
        byte_q.insert(byte_q.size(), {1'b0, b});
    endfunction

    function automatic void put_end();
        byte_q.insert(byte_q.size(), 9'h100);
    endfunction

    function automatic void put_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            put_byte(v[i*8 +: 8]);
    endfunction

    function automatic void put_string(input int len);
        int form;
        form = $urandom_range(0, 3);
        if (form == 0 || len > 31)
        begin
            put_byte(TAG_STR8);
            put_be(64'(len), 1);
        end
        else if (form == 1)
        begin
            put_byte(TAG_STR16);
            put_be(64'(len), 2);
        end
        else if (form == 2)
        begin
            put_byte(TAG_STR32);
            put_be(64'(len), 4);
        end
        else
            put_byte(TAG_FIXSTR_MIN | {3'b000, len[4:0]});
        for (int i = 0; i < len; i++)
            put_byte(8'($urandom_range(0, 255)));
    endfunction

    // Append one well-formed value with random content; no containers are picked from level 5 on.
    function automatic void put_value(input int lvl);
        int pick;
        int n;
        pick = $urandom_range(0, (lvl < 5) ? 19 : 13);
        n = $urandom_range(0, 3);
        case (pick)
            0:  put_byte(8'($urandom_range(0, 127)));
            1:  put_byte(8'($urandom_range(224, 255)));
            2:  put_byte(TAG_NIL);
            3:  put_byte($urandom_range(0, 1) ? TAG_TRUE : TAG_FALSE);
            4:  begin put_byte(TAG_F32); put_be({$urandom, $urandom}, 4); end
            5:  begin put_byte(TAG_F64); put_be({$urandom, $urandom}, 8); end
            6:  begin put_byte(TAG_U8); put_be(64'($urandom), 1); end
            7:  begin put_byte(TAG_U16); put_be(64'($urandom), 2); end
            8:  begin put_byte(TAG_U32); put_be(64'($urandom), 4); end
            9:  begin put_byte(TAG_U64); put_be({$urandom, $urandom}, 8); end
            10: begin put_byte(TAG_I8); put_be(64'($urandom), 1); end
            11: begin put_byte(TAG_I16); put_be(64'($urandom), 2); end
            12: begin put_byte($urandom_range(0, 1) ? TAG_I32 : TAG_I64);
                      put_be({$urandom, $urandom}, byte_q[$][7:0] == TAG_I32 ? 4 : 8); end
            13: put_string($urandom_range(0, 9) == 0 ? 31 : $urandom_range(0, 4));
            14, 15, 16:
            begin
                case ($urandom_range(0, 2))
                    0: put_byte(TAG_FIXARR_MIN | {4'b0000, n[3:0]});
                    1: begin put_byte(TAG_ARR16); put_be(64'(n), 2); end
                    default: begin put_byte(TAG_ARR32); put_be(64'(n), 4); end
                endcase
                for (int i = 0; i < n; i++)
                    put_value(lvl + 1);
            end
            default:
            begin
                case ($urandom_range(0, 2))
                    0: put_byte(TAG_FIXMAP_MIN | {4'b0000, n[3:0]});
                    1: begin put_byte(TAG_MAP16); put_be(64'(n), 2); end
                    default: begin put_byte(TAG_MAP32); put_be(64'(n), 4); end
                endcase
                for (int i = 0; i < n; i++)
                begin
                    put_string($urandom_range(0, 3));
                    put_value(lvl + 1);
                end
            end
        endcase
    endfunction

    // One buffer: mostly well formed, some truncated, trailing, corrupted or pure noise.
    function automatic void put_buffer();
        int flaw;
        int cut;
        flaw = $urandom_range(0, 19);
        if (flaw == 0)
        begin
            repeat ($urandom_range(0, 6))
                put_byte(8'($urandom_range(0, 255)));
        end
        else
        begin
            put_value(0);
            if (flaw == 1 && byte_q.size() > 0 && !byte_q[$][8])
                void'(byte_q.pop_back());
            else if (flaw == 2)
                put_byte(8'($urandom_range(0, 255)));
            else if (flaw == 3)
            begin
                cut = $urandom_range(0, 2);
                if (byte_q.size() > cut && !byte_q[byte_q.size()-1-cut][8])
                    byte_q[byte_q.size()-1-cut] = {1'b0, 8'($urandom)};
            end
        end
        put_end();
    endfunction

    task automatic send_queue();
        in_item_t it;
        logic     took;
        while (byte_q.size() > 0)
        begin
            if (burst_left == 0)
            begin
                in_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
                burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 12);
            end
            it.data_byte = byte_q[0][7:0];
            it.end_marker = byte_q[0][8];
            void'(byte_q.pop_front());
            in_ch.valid <= 1'b1;
            in_ch.payload <= it;
            forever
            begin
                @(negedge clk);
                took = in_ch.ready;
                @(posedge clk);
                if (took)
                    break;
            end
            beats_sent++;
            burst_left--;
        end
        in_ch.valid <= 1'b0;
    endtask

    // Hold until every token has come back, then let the stack pops settle.
    task automatic drain();
        int guard;
        guard = 0;
        while (tokens_due != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (40)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [4:0] v);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        logic [4:0] limits [5];
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_ch.valid = 1'b0;
        in_ch.payload = '0;
        beats_sent = 0;
        burst_left = 0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty, extremes, map keys, bad tags, trailing, truncated.
        put_end();
        put_byte(TAG_U64); put_be('1, 8); put_end();
        put_byte(TAG_I64); put_be(64'h8000_0000_0000_0000, 8); put_end();
        put_byte(TAG_FIXMAP_MIN | 8'd1); put_byte(TAG_FIXSTR_MIN | 8'd1); put_byte(8'h6b);
        put_byte(TAG_TRUE); put_end();
        put_byte(TAG_FIXMAP_MIN | 8'd1); put_byte(8'h01); put_byte(8'h02); put_end();
        put_byte(8'hc1); put_end();
        put_byte(8'h00); put_byte(8'hff); put_end();
        put_byte(TAG_FIXARR_MIN | 8'd2); put_byte(TAG_POSFIX_MAX); put_end();
        send_queue();
        drain();
        write_limit(5'd1);
        put_byte(TAG_FIXARR_MIN | 8'd1); put_byte(TAG_FIXARR_MIN); put_end();
        put_byte(TAG_ARR16); put_be(64'd0, 2); put_byte(TAG_NEGFIX_MIN); put_end();
        send_queue();
        drain();

        limits = '{5'd16, 5'd3, 5'd31, 5'd0, 5'd1};
        foreach (limits[i])
        begin
            write_limit(limits[i]);
            while (byte_q.size() < 90)
                put_buffer();
            send_queue();
            drain();
        end
        write_limit(DEPTH_LIMIT_RESET);
        while (byte_q.size() < 90)
            put_buffer();
        send_queue();
        drain();

        if (mismatches == 0 && tokens_due == 0)
            $display("msgpack_stream_decoder regression: pass");
        else
            $display("msgpack_stream_decoder regression: fail");
        $finish;
    end

endmodule
`default_nettype wire

FILE: files.f
rtl/core/msd_pkg.sv
rtl/core/msd_if.sv
rtl/core/msd_stack_mem.sv
rtl/core/msgpack_stream_decoder.sv
test/msd_token_checker.sv
test/tb.sv
